// ===== rtl/core/nnta_pkg.sv =====
// shared types and constants of the nearest-neighbour track id assigner
`timescale 1ns / 1ps

package nnta_pkg;

   // fixed field widths
   localparam int COORD_W         = 16;
   localparam int TRACK_ID_W      = 4;
   localparam int CSR_W           = 5;
   localparam int MAX_TRACKED_DEF = 16;

   // one detection item
   typedef struct packed {
      logic signed [COORD_W-1:0] pos_x;
      logic signed [COORD_W-1:0] pos_y;
      logic                      frame_end;
   } req_type;

   // one result item
   typedef struct packed {
      logic [TRACK_ID_W-1:0] track_id;
      logic [1:0]            status;
      logic                  run_end;
   } rsp_type;

   // result status codes
   typedef enum logic [1:0] {
      STAT_MATCHED  = 2'd0,
      STAT_INITIAL  = 2'd1,
      STAT_IGNORED  = 2'd2,
      STAT_NO_ENTRY = 2'd3
   } status_type;

   // sequencer states
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DECODE,
      ST_INIT_RD,
      ST_INIT_WR,
      ST_SCAN_RD,
      ST_SCAN_DIFF,
      ST_SCAN_SQX,
      ST_SCAN_SQY,
      ST_SCAN_CMP,
      ST_ASSIGN,
      ST_MERGE_OLD_RD,
      ST_MERGE_OLD_WR,
      ST_MERGE_NEW_RD,
      ST_MERGE_NEW_WR
   } state_type;

endpackage

// ===== rtl/core/nnta_ram.sv =====
// generic simple dual-port ram with registered read
`timescale 1ns / 1ps

module nnta_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      rd_data <= mem[rd_addr];
   end

endmodule

// ===== rtl/core/nearest_neighbour_track_id_assigner_unit.sv =====
// top level of the greedy nearest-neighbour track id assigner
`timescale 1ns / 1ps

// Detections arrive one item at a time (start while busy is low) and each
// item is worked on alone; busy stays high until its results are formed.
// Results leave in the cycle after they are formed, one per cycle at most,
// and cannot be stalled. Before tracking, a detection is buffered; the
// frame end that starts tracking copies each buffered detection into the
// table with a read and a write step per assigned id. While tracking, one
// shared multiplier squares dx and dy of each unused entry in turn, read
// through a registered table ram; used entries are skipped. A frame end
// while tracking adds the table merge: kept old entries are compacted to
// the front, then this frame's matched detections are appended.
// The tracked count may be written whenever the block is idle.
module nearest_neighbour_track_id_assigner_unit #(
   parameter int MAX_TRACKED = nnta_pkg::MAX_TRACKED_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  nnta_pkg::req_type          req_data,
   output logic                       busy,
   output logic                       rsp_valid,
   output nnta_pkg::rsp_type          rsp_data,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [nnta_pkg::CSR_W-1:0] csr_data
);

   import nnta_pkg::*;

   localparam int IDX_W  = $clog2(MAX_TRACKED);
   localparam int CNT_W  = $clog2(MAX_TRACKED + 1);
   localparam int ENT_W  = 2 * COORD_W + IDX_W;
   localparam int DIFF_W = COORD_W + 1;
   localparam int SQ_W   = 2 * DIFF_W;
   localparam int DIST_W = SQ_W + 1;
   localparam int TC_W   = (CNT_W > CSR_W) ? CNT_W : CSR_W;
   localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_TRACKED);

   // registers
   state_type                state_ff, state_in;
   req_type                  item_ff, item_in;
   logic                     tracking_ff, tracking_in;
   logic                     ovf_ff, ovf_in;
   logic [CNT_W-1:0]         old_count_ff, old_count_in;
   logic [CNT_W-1:0]         new_count_ff, new_count_in;
   logic [MAX_TRACKED-1:0]   used_ff, used_in;
   logic [CNT_W-1:0]         idx_ff, idx_in;
   logic [CNT_W-1:0]         wr_ff, wr_in;
   logic signed [DIFF_W-1:0] dx_ff, dx_in;
   logic signed [DIFF_W-1:0] dy_ff, dy_in;
   logic [SQ_W-1:0]          sqx_ff, sqx_in;
   logic [SQ_W-1:0]          sqy_ff, sqy_in;
   logic [IDX_W-1:0]         cand_id_ff, cand_id_in;
   logic                     found_ff, found_in;
   logic [DIST_W-1:0]        best_dist_ff, best_dist_in;
   logic [IDX_W-1:0]         best_idx_ff, best_idx_in;
   logic [IDX_W-1:0]         best_id_ff, best_id_in;
   logic [CSR_W-1:0]         tracked_count_ff, tracked_count_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   rsp_type                  rsp_data_ff, rsp_data_in;

   // ram ports
   logic             old_we, new_we;
   logic [IDX_W-1:0] old_waddr, new_waddr;
   logic [ENT_W-1:0] old_wdata, new_wdata;
   logic [ENT_W-1:0] old_rdata, new_rdata;

   // datapath signals
   logic signed [COORD_W-1:0] old_x, old_y, new_x, new_y;
   logic [IDX_W-1:0]          old_id;
   logic signed [DIFF_W-1:0]  mul_a;
   logic signed [SQ_W-1:0]    mul_p;
   logic [DIST_W-1:0]         sum_sq;
   logic [CNT_W-1:0]          idx_nx, new_count_nx;
   logic [CNT_W-1:0]          cnt_after;
   logic                      ovf_after, buf_room, count_match;

   // emitted result fields
   logic [IDX_W-1:0]            emit_id;
   logic [IDX_W+TRACK_ID_W-1:0] emit_ext;
   status_type                  emit_status;
   logic                        emit_last;

   // table and frame buffer
   nnta_ram #(
      .WIDTH (ENT_W),
      .DEPTH (MAX_TRACKED)
   ) u_old_ram (
      .clock   (clock),
      .wr_en   (old_we),
      .wr_addr (old_waddr),
      .wr_data (old_wdata),
      .rd_addr (idx_ff[IDX_W-1:0]),
      .rd_data (old_rdata)
   );

   nnta_ram #(
      .WIDTH (ENT_W),
      .DEPTH (MAX_TRACKED)
   ) u_new_ram (
      .clock   (clock),
      .wr_en   (new_we),
      .wr_addr (new_waddr),
      .wr_data (new_wdata),
      .rd_addr (idx_ff[IDX_W-1:0]),
      .rd_data (new_rdata)
   );

   // entry fields: x, y, id
   assign old_x  = old_rdata[ENT_W-1 -: COORD_W];
   assign old_y  = old_rdata[IDX_W+COORD_W-1 -: COORD_W];
   assign old_id = old_rdata[IDX_W-1:0];
   assign new_x  = new_rdata[ENT_W-1 -: COORD_W];
   assign new_y  = new_rdata[IDX_W+COORD_W-1 -: COORD_W];

   // shared squaring unit
   assign mul_a  = (state_ff == ST_SCAN_SQX) ? dx_ff : dy_ff;
   assign mul_p  = SQ_W'(mul_a) * SQ_W'(mul_a);
   assign sum_sq = DIST_W'(sqx_ff) + DIST_W'(sqy_ff);

   // counters and frame bookkeeping
   assign idx_nx       = idx_ff + 1'b1;
   assign new_count_nx = new_count_ff + 1'b1;
   assign buf_room     = new_count_ff < MAX_CNT;
   assign cnt_after    = buf_room ? new_count_nx : new_count_ff;
   assign ovf_after    = ovf_ff | ~buf_room;
   assign count_match  = TC_W'(cnt_after) == TC_W'(tracked_count_ff);

   // sequencer: next state and datapath control
   always_comb begin
      state_in         = state_ff;
      item_in          = item_ff;
      tracking_in      = tracking_ff;
      ovf_in           = ovf_ff;
      old_count_in     = old_count_ff;
      new_count_in     = new_count_ff;
      used_in          = used_ff;
      idx_in           = idx_ff;
      wr_in            = wr_ff;
      dx_in            = dx_ff;
      dy_in            = dy_ff;
      sqx_in           = sqx_ff;
      sqy_in           = sqy_ff;
      cand_id_in       = cand_id_ff;
      found_in         = found_ff;
      best_dist_in     = best_dist_ff;
      best_idx_in      = best_idx_ff;
      best_id_in       = best_id_ff;
      tracked_count_in = csr_valid ? csr_data : tracked_count_ff;
      rsp_valid_in     = 1'b0;
      emit_id          = '0;
      emit_status      = STAT_MATCHED;
      emit_last        = 1'b1;
      old_we           = 1'b0;
      old_waddr        = wr_ff[IDX_W-1:0];
      old_wdata        = old_rdata;
      new_we           = 1'b0;
      new_waddr        = new_count_ff[IDX_W-1:0];
      new_wdata        = {item_ff.pos_x, item_ff.pos_y, {IDX_W{1'b0}}};

      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               item_in  = req_data;
               state_in = ST_DECODE;
            end
         end

         ST_DECODE: begin
            if (!tracking_ff) begin
               // buffer the detection until the frame is complete
               new_we       = buf_room;
               new_count_in = cnt_after;
               ovf_in       = ovf_after;
               if (!item_ff.frame_end) begin
                  state_in = ST_IDLE;
               end else if (!ovf_after && count_match) begin
                  idx_in   = '0;
                  state_in = ST_INIT_RD;
               end else begin
                  rsp_valid_in = 1'b1;
                  emit_status  = STAT_IGNORED;
                  new_count_in = '0;
                  ovf_in       = 1'b0;
                  state_in     = ST_IDLE;
               end
            end else begin
               idx_in   = '0;
               found_in = 1'b0;
               state_in = ST_SCAN_RD;
            end
         end

         ST_INIT_RD: begin
            state_in = ST_INIT_WR;
         end

         ST_INIT_WR: begin
            // copy buffered detection into the table with id = arrival order
            old_we       = 1'b1;
            old_waddr    = idx_ff[IDX_W-1:0];
            old_wdata    = {new_x, new_y, idx_ff[IDX_W-1:0]};
            rsp_valid_in = 1'b1;
            emit_id      = idx_ff[IDX_W-1:0];
            emit_status  = STAT_INITIAL;
            emit_last    = (idx_nx == new_count_ff);
            idx_in       = idx_nx;
            if (idx_nx == new_count_ff) begin
               old_count_in = new_count_ff;
               tracking_in  = 1'b1;
               new_count_in = '0;
               ovf_in       = 1'b0;
               used_in      = '0;
               state_in     = ST_IDLE;
            end else begin
               state_in = ST_INIT_RD;
            end
         end

         ST_SCAN_RD: begin
            // skip used entries without a ram read
            if (idx_ff >= old_count_ff) begin
               state_in = ST_ASSIGN;
            end else if (used_ff[idx_ff[IDX_W-1:0]]) begin
               idx_in = idx_nx;
            end else begin
               state_in = ST_SCAN_DIFF;
            end
         end

         ST_SCAN_DIFF: begin
            dx_in      = DIFF_W'(item_ff.pos_x) - DIFF_W'(old_x);
            dy_in      = DIFF_W'(item_ff.pos_y) - DIFF_W'(old_y);
            cand_id_in = old_id;
            state_in   = ST_SCAN_SQX;
         end

         ST_SCAN_SQX: begin
            sqx_in   = mul_p;
            state_in = ST_SCAN_SQY;
         end

         ST_SCAN_SQY: begin
            sqy_in   = mul_p;
            state_in = ST_SCAN_CMP;
         end

         ST_SCAN_CMP: begin
            // strict compare keeps the lowest index on ties
            if (!found_ff || (sum_sq < best_dist_ff)) begin
               found_in     = 1'b1;
               best_dist_in = sum_sq;
               best_idx_in  = idx_ff[IDX_W-1:0];
               best_id_in   = cand_id_ff;
            end
            idx_in   = idx_nx;
            state_in = ST_SCAN_RD;
         end

         ST_ASSIGN: begin
            rsp_valid_in = 1'b1;
            if (found_ff) begin
               used_in[best_idx_ff] = 1'b1;
               new_we               = buf_room;
               new_wdata            = {item_ff.pos_x, item_ff.pos_y, best_id_ff};
               new_count_in         = cnt_after;
               emit_id              = best_id_ff;
               emit_status          = STAT_MATCHED;
            end else begin
               emit_status = STAT_NO_ENTRY;
            end
            if (item_ff.frame_end) begin
               idx_in   = '0;
               wr_in    = '0;
               state_in = ST_MERGE_OLD_RD;
            end else begin
               state_in = ST_IDLE;
            end
         end

         ST_MERGE_OLD_RD: begin
            // compact unused old entries to the front
            if (idx_ff >= old_count_ff) begin
               idx_in   = '0;
               state_in = ST_MERGE_NEW_RD;
            end else if (used_ff[idx_ff[IDX_W-1:0]]) begin
               idx_in = idx_nx;
            end else begin
               idx_in   = idx_nx;
               state_in = ST_MERGE_OLD_WR;
            end
         end

         ST_MERGE_OLD_WR: begin
            old_we    = 1'b1;
            old_wdata = old_rdata;
            wr_in     = wr_ff + 1'b1;
            state_in  = ST_MERGE_OLD_RD;
         end

         ST_MERGE_NEW_RD: begin
            // append this frame's matched detections
            if ((idx_ff >= new_count_ff) || (wr_ff >= MAX_CNT)) begin
               old_count_in = wr_ff;
               used_in      = '0;
               new_count_in = '0;
               ovf_in       = 1'b0;
               state_in     = ST_IDLE;
            end else begin
               idx_in   = idx_nx;
               state_in = ST_MERGE_NEW_WR;
            end
         end

         ST_MERGE_NEW_WR: begin
            old_we    = 1'b1;
            old_wdata = new_rdata;
            wr_in     = wr_ff + 1'b1;
            state_in  = ST_MERGE_NEW_RD;
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // result payload, id masked to the port width
      emit_ext             = {{TRACK_ID_W{1'b0}}, emit_id};
      rsp_data_in          = rsp_data_ff;
      if (rsp_valid_in) begin
         rsp_data_in.track_id = emit_ext[TRACK_ID_W-1:0];
         rsp_data_in.status   = emit_status;
         rsp_data_in.run_end  = emit_last;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= ST_IDLE;
         tracking_ff      <= 1'b0;
         ovf_ff           <= 1'b0;
         old_count_ff     <= '0;
         new_count_ff     <= '0;
         used_ff          <= '0;
         found_ff         <= 1'b0;
         tracked_count_ff <= CSR_W'(1);
         rsp_valid_ff     <= 1'b0;
      end else begin
         state_ff         <= state_in;
         tracking_ff      <= tracking_in;
         ovf_ff           <= ovf_in;
         old_count_ff     <= old_count_in;
         new_count_ff     <= new_count_in;
         used_ff          <= used_in;
         found_ff         <= found_in;
         tracked_count_ff <= tracked_count_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      item_ff      <= item_in;
      idx_ff       <= idx_in;
      wr_ff        <= wr_in;
      dx_ff        <= dx_in;
      dy_ff        <= dy_in;
      sqx_ff       <= sqx_in;
      sqy_ff       <= sqy_in;
      cand_id_ff   <= cand_id_in;
      best_dist_ff <= best_dist_in;
      best_idx_ff  <= best_idx_in;
      best_id_ff   <= best_id_in;
      rsp_data_ff  <= rsp_data_in;
   end

   // ports
   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign csr_ready = 1'b1;

endmodule

// ===== tb/nearest_neighbour_track_id_assigner_unit_test.sv =====
// self-checking testbench of the nearest-neighbour track id assigner unit
`timescale 1ns / 1ps

module nearest_neighbour_track_id_assigner_unit_test;
   import nnta_pkg::*;

   localparam int DEPTH        = MAX_TRACKED_DEF;
   localparam int SETTLE_WAIT  = 64;
   localparam int STALL_LIMIT  = 4000;
   localparam int RANDOM_ITEMS = 205;

   logic             clock;
   logic             reset;
   logic             start;
   req_type          req_data;
   logic             busy;
   logic             rsp_valid;
   rsp_type          rsp_data;
   logic             csr_valid;
   logic             csr_ready;
   logic [CSR_W-1:0] csr_data;

   // one row of the directed stimulus table
   typedef struct {
      bit               csr_write;
      logic [CSR_W-1:0] csr_value;
      req_type          item;
      bit               typed;
      rsp_type          result;
   } stim_row_type;

   stim_row_type directed_rows[$];

   // predicted table of tracked positions and the frame being collected
   logic signed [COORD_W-1:0] trk_x [DEPTH];
   logic signed [COORD_W-1:0] trk_y [DEPTH];
   logic [TRACK_ID_W-1:0]     trk_id [DEPTH];
   bit                        trk_used [DEPTH];
   int                        trk_count;
   logic signed [COORD_W-1:0] det_x [DEPTH];
   logic signed [COORD_W-1:0] det_y [DEPTH];
   logic [TRACK_ID_W-1:0]     det_id [DEPTH];
   int                        det_count;
   bit                        det_overflow;
   bit                        tracking;
   logic [CSR_W-1:0]          wanted_count;

   rsp_type awaited_ids[$];
   rsp_type ignored_result;
   rsp_type no_result;

   int error_count;
   int stall_cycles;
   int items_sent;
   int random_base;
   int sender_idle_pct;

   nearest_neighbour_track_id_assigner_unit DUT (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .req_data  (req_data),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   // 10 ns clock
   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   function automatic void push_result(input logic [TRACK_ID_W-1:0] id, input status_type st,
                                       input logic last);
      rsp_type r;
      r.track_id = id;
      r.status   = st;
      r.run_end  = last;
      awaited_ids = {awaited_ids, r};
   endfunction

   // greedy nearest-neighbour id assignment for one detection
   function automatic void compute_track_ids(input req_type d);
      longint                    dx;
      longint                    dy;
      longint                    sq_dist;
      longint                    best_dist;
      int                        best;
      bit                        found;
      int                        i;
      int                        n;
      logic signed [COORD_W-1:0] mx [DEPTH];
      logic signed [COORD_W-1:0] my [DEPTH];
      logic [TRACK_ID_W-1:0]     mid [DEPTH];
      found     = 1'b0;
      best      = 0;
      best_dist = 0;
      n         = 0;
      // collecting the first frame
      if (!tracking) begin
         if (det_count < DEPTH) begin
            det_x[det_count] = d.pos_x;
            det_y[det_count] = d.pos_y;
            det_count++;
         end else begin
            det_overflow = 1'b1;
         end
         if (!d.frame_end) return;
         if (!det_overflow && det_count == int'(wanted_count)) begin
            for (i = 0; i < det_count; i++) begin
               trk_x[i]    = det_x[i];
               trk_y[i]    = det_y[i];
               trk_id[i]   = TRACK_ID_W'(i);
               trk_used[i] = 1'b0;
               push_result(TRACK_ID_W'(i), STAT_INITIAL, i == det_count - 1);
            end
            trk_count = det_count;
            tracking  = 1'b1;
         end else begin
            push_result('0, STAT_IGNORED, 1'b1);
         end
         det_count    = 0;
         det_overflow = 1'b0;
         return;
      end
      // nearest unused entry, lowest index wins ties
      for (i = 0; i < trk_count; i++) begin
         if (!trk_used[i]) begin
            dx      = longint'($signed(d.pos_x)) - longint'($signed(trk_x[i]));
            dy      = longint'($signed(d.pos_y)) - longint'($signed(trk_y[i]));
            sq_dist = dx * dx + dy * dy;
            if (!found || sq_dist < best_dist) begin
               found     = 1'b1;
               best      = i;
               best_dist = sq_dist;
            end
         end
      end
      if (found) begin
         trk_used[best] = 1'b1;
         if (det_count < DEPTH) begin
            det_x[det_count]  = d.pos_x;
            det_y[det_count]  = d.pos_y;
            det_id[det_count] = trk_id[best];
            det_count++;
         end
         push_result(trk_id[best], STAT_MATCHED, 1'b1);
      end else begin
         push_result('0, STAT_NO_ENTRY, 1'b1);
      end
      // frame end: unused old entries first, then this frame's matches
      if (d.frame_end) begin
         for (i = 0; i < trk_count; i++) begin
            if (!trk_used[i]) begin
               mx[n]  = trk_x[i];
               my[n]  = trk_y[i];
               mid[n] = trk_id[i];
               n++;
            end
         end
         for (i = 0; i < det_count && n < DEPTH; i++) begin
            mx[n]  = det_x[i];
            my[n]  = det_y[i];
            mid[n] = det_id[i];
            n++;
         end
         for (i = 0; i < n; i++) begin
            trk_x[i]  = mx[i];
            trk_y[i]  = my[i];
            trk_id[i] = mid[i];
         end
         for (i = 0; i < DEPTH; i++) trk_used[i] = 1'b0;
         trk_count    = n;
         det_count    = 0;
         det_overflow = 1'b0;
      end
   endfunction

   function automatic logic [COORD_W-1:0] edge_coord();
      case ($urandom_range(5))
         0:       return 16'h8000;
         1:       return 16'h8001;
         2:       return 16'hffff;
         3:       return 16'h0000;
         4:       return 16'h0001;
         default: return 16'h7fff;
      endcase
   endfunction

   // random detection: full range, edges, coarse grid for ties, or near a track
   function automatic req_type random_detection(input bit last);
      req_type     d;
      int          k;
      int          mode;
      logic [31:0] rx;
      logic [31:0] ry;
      rx        = $urandom();
      ry        = $urandom();
      mode      = $urandom_range(99);
      d.pos_x   = rx[COORD_W-1:0];
      d.pos_y   = ry[COORD_W-1:0];
      if (mode < 10) begin
         d.pos_x = edge_coord();
         d.pos_y = edge_coord();
      end else if (mode < 30) begin
         d.pos_x = COORD_W'(int'($urandom_range(4)) * 256 - 512);
         d.pos_y = COORD_W'(int'($urandom_range(4)) * 256 - 512);
      end else if (mode < 75 && trk_count > 0) begin
         k       = $urandom_range(trk_count - 1);
         d.pos_x = trk_x[k] + COORD_W'(rx[25:16]) - COORD_W'(512);
         d.pos_y = trk_y[k] + COORD_W'(ry[25:16]) - COORD_W'(512);
      end
      d.frame_end = last;
      return d;
   endfunction

   task automatic add_row(input bit w, input logic [CSR_W-1:0] v, input logic [COORD_W-1:0] x,
                          input logic [COORD_W-1:0] y, input bit fe, input bit typed);
      stim_row_type row;
      row.csr_write       = w;
      row.csr_value       = v;
      row.item.pos_x      = x;
      row.item.pos_y      = y;
      row.item.frame_end  = fe;
      row.typed           = typed;
      row.result          = typed ? ignored_result : no_result;
      directed_rows = {directed_rows, row};
   endtask

   // present one item and predict its results once it is taken
   task automatic send_item(input req_type item, input bit typed, input rsp_type typed_result);
      int mark;
      int done;
      if (random_base >= 0) begin
         done = items_sent - random_base;
         sender_idle_pct = (done < RANDOM_ITEMS / 3) ? 25 :
                           (done < 2 * RANDOM_ITEMS / 3) ? 71 : 0;
      end
      while ($urandom_range(99) < sender_idle_pct) begin
         start = 1'b0;
         @(negedge clock);
      end
      start    = 1'b1;
      req_data = item;
      @(posedge clock);
      while (busy) @(posedge clock);
      mark = awaited_ids.size();
      compute_track_ids(item);
      if (typed) begin
         while (awaited_ids.size() > mark) void'(awaited_ids.pop_back());
         awaited_ids = {awaited_ids, typed_result};
      end
      items_sent++;
      @(negedge clock);
   endtask

   // hold the sender until every result is back and the block is idle
   task automatic drain_results();
      start = 1'b0;
      while (awaited_ids.size() != 0) @(negedge clock);
      repeat (SETTLE_WAIT) @(negedge clock);
      while (busy) @(negedge clock);
   endtask

   task automatic write_tracked_count(input logic [CSR_W-1:0] value);
      drain_results();
      csr_valid = 1'b1;
      csr_data  = value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      wanted_count = value;
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   task automatic send_random_frame(input int frame_len);
      int i;
      for (i = 0; i < frame_len; i++)
         send_item(random_detection(i == frame_len - 1), 1'b0, no_result);
   endtask

   // compare each result with the oldest expectation
   always @(posedge clock) begin : result_check
      rsp_type want;
      if (!reset && rsp_valid) begin
         if (awaited_ids.size() == 0) begin
            $display("%0t: result with none expected: track_id %0d status %0d run_end %0d",
                     $time, rsp_data.track_id, rsp_data.status, rsp_data.run_end);
            error_count++;
         end else begin
            want = awaited_ids.pop_front();
            if (rsp_data.track_id !== want.track_id) begin
               $display("%0t: track_id expected %0d actual %0d", $time, want.track_id,
                        rsp_data.track_id);
               error_count++;
            end
            if (rsp_data.status !== want.status) begin
               $display("%0t: status expected %0d actual %0d", $time, want.status,
                        rsp_data.status);
               error_count++;
            end
            if (rsp_data.run_end !== want.run_end) begin
               $display("%0t: run_end expected %0d actual %0d", $time, want.run_end,
                        rsp_data.run_end);
               error_count++;
            end
         end
      end
   end

   // watchdog on cycles without any handshake
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid || (csr_valid && csr_ready))
         stall_cycles <= 0;
      else
         stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
         $display("[nearest_neighbour_track_id_assigner_unit] ERROR");
         $finish;
      end
   end

   initial begin : stimulus
      int               i;
      int               frame_len;
      int               choice;
      logic [CSR_W-1:0] cfg;
      start        = 1'b0;
      req_data     = '0;
      csr_valid    = 1'b0;
      csr_data     = '0;
      reset        = 1'b1;
      items_sent   = 0;
      random_base  = -1;
      sender_idle_pct = 25;
      trk_count    = 0;
      det_count    = 0;
      det_overflow = 1'b0;
      tracking     = 1'b0;
      wanted_count = 5'd1;
      for (i = 0; i < DEPTH; i++) trk_used[i] = 1'b0;
      no_result               = '0;
      ignored_result.track_id = '0;
      ignored_result.status   = STAT_IGNORED;
      ignored_result.run_end  = 1'b1;

      // directed table: counts that can never match, buffer overflow, wrong size
      add_row(1'b1, 5'd0, 16'h8000, 16'h8000, 1'b1, 1'b1);
      add_row(1'b1, 5'd31, 16'h7fff, 16'h7fff, 1'b1, 1'b1);
      add_row(1'b1, 5'd17, 16'h0000, 16'h0000, 1'b1, 1'b1);
      for (i = 0; i <= DEPTH; i++)
         add_row(i == 0, 5'd16, (i % 2) ? 16'h7fff : 16'h8000, COORD_W'(i * 16'h1111),
                 i == DEPTH, i == DEPTH);
      add_row(1'b1, 5'd1, 16'hffff, 16'h0001, 1'b0, 1'b0);
      add_row(1'b1, 5'd1, 16'h0001, 16'hffff, 1'b1, 1'b1);

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (directed_rows[r]) begin
         if (directed_rows[r].csr_write) write_tracked_count(directed_rows[r].csr_value);
         send_item(directed_rows[r].item, directed_rows[r].typed, directed_rows[r].result);
      end

      // random frames that cannot start tracking
      random_base = items_sent;
      repeat (4) begin
         cfg = CSR_W'($urandom_range(31));
         write_tracked_count(cfg);
         frame_len = ($urandom_range(3) == 0) ? $urandom_range(17, 19) : $urandom_range(1, 5);
         if (frame_len == int'(cfg)) frame_len++;
         send_random_frame(frame_len);
      end

      // full table start
      write_tracked_count(5'(DEPTH));
      send_random_frame(DEPTH);

      // tracking frames, now and then longer than the table
      while (items_sent - random_base < RANDOM_ITEMS) begin
         frame_len = ($urandom_range(9) == 0) ? $urandom_range(17, 19) :
                                                $urandom_range(1, DEPTH);
         send_random_frame(frame_len);
         choice = $urandom_range(7);
         if (choice == 0) begin
            case ($urandom_range(3))
               0:       write_tracked_count(5'd0);
               1:       write_tracked_count(5'd31);
               2:       write_tracked_count(5'd1);
               default: write_tracked_count(5'($urandom_range(31)));
            endcase
         end else if (choice == 1) begin
            drain_results();
         end
      end

      drain_results();
      if (error_count == 0)
         $display("[nearest_neighbour_track_id_assigner_unit] OK");
      else
         $display("[nearest_neighbour_track_id_assigner_unit] ERROR");
      $finish;
   end

endmodule

// ===== nearest_neighbour_track_id_assigner_unit.f =====
rtl/core/nnta_pkg.sv
rtl/core/nnta_ram.sv
rtl/core/nearest_neighbour_track_id_assigner_unit.sv
tb/nearest_neighbour_track_id_assigner_unit_test.sv
